// ----- rtl/core/ogf_pkg.sv -----
// Package for the occupancy grid fusion block.
// Holds sizes, result codes and the command and status structs used by
// ogf_ctrl, ogf_dp, the top level and the testbench. It depends on nothing else.
`timescale 1ns / 1ps

package ogf_pkg;

   localparam int MAP_CELLS  = 65536;
   localparam int COUNT_BITS = 16;

   localparam int IDX_BITS   = $clog2(MAP_CELLS);
   localparam int OFFS_BITS  = 16;
   localparam int LOCAL_BITS = 10;
   localparam int DIM_BITS   = 16;
   localparam int COORD_BITS = OFFS_BITS + 1;
   localparam int PROD_BITS  = DIM_BITS + COORD_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int VALUE_BITS = 8;
   localparam int CLASS_BITS = 2;
   localparam int TOTAL_BITS = 16;
   localparam int ENTRY_BITS = 2 * COUNT_BITS;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 16'd256;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 16'd256;

   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_CLASSIFY   = 1'b1;

   localparam logic signed [VALUE_BITS-1:0] VALUE_BLOCKED = 8'sd100;
   localparam logic signed [VALUE_BITS-1:0] VALUE_FREE    = 8'sd0;

   localparam logic [CLASS_BITS-1:0] CLASS_UNKNOWN  = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_FREE     = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_OCCUPIED = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   typedef struct packed {
      logic clear;
      logic load;
      logic calc;
      logic index;
      logic read;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/core/ogf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the cell counter store. It depends on nothing else.
`timescale 1ns / 1ps

module ogf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ogf_ctrl.sv -----
// Controller state machine of the occupancy grid fusion block.
// Sequences the clearing pass and the steps of each item; uses ogf_pkg.
`timescale 1ns / 1ps

module ogf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ogf_pkg::sts_type sts,
   output ogf_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CALC,
      S_INDEX,
      S_READ,
      S_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept = req_tvalid && ready_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_CALC;
            end
         end
         S_CALC:  state_in = S_INDEX;
         S_INDEX: state_in = S_READ;
         S_READ:  state_in = S_WRITE;
         S_WRITE: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_tready = ready_ff;

   always_comb begin
      cmd       = '0;
      cmd.clear = (state_ff == S_CLEAR);
      cmd.load  = accept;
      cmd.calc  = (state_ff == S_CALC);
      cmd.index = (state_ff == S_INDEX);
      cmd.read  = (state_ff == S_READ);
      cmd.write = (state_ff == S_WRITE) && sts.out_free;
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("item accepted during clearing pass");

   a_accept_starts_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CALC))
      else $error("accepted item did not start processing");

   a_write_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> (state_ff == S_IDLE) && req_tready)
      else $error("controller did not return to idle after result");

endmodule

// ----- rtl/core/ogf_dp.sv -----
// Datapath of the occupancy grid fusion block: address forming, counter
// store, update and classify logic, result register. Uses ogf_pkg, ogf_ram.
`timescale 1ns / 1ps

module ogf_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ogf_pkg::cmd_type                       cmd,
   output ogf_pkg::sts_type                       sts,
   input  logic                                   csr_write,
   input  logic                                   csr_index,
   input  logic [ogf_pkg::DIM_BITS-1:0]           csr_data,
   input  logic                                   req_operation,
   input  logic [ogf_pkg::OFFS_BITS-1:0]          req_offset_x,
   input  logic [ogf_pkg::OFFS_BITS-1:0]          req_offset_y,
   input  logic [ogf_pkg::LOCAL_BITS-1:0]         req_local_col,
   input  logic [ogf_pkg::LOCAL_BITS-1:0]         req_local_row,
   input  logic signed [ogf_pkg::VALUE_BITS-1:0]  req_cell_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ogf_pkg::CLASS_BITS-1:0]         rsp_cell_class,
   output logic [ogf_pkg::TOTAL_BITS-1:0]         rsp_seen_total,
   output logic                                   rsp_out_of_map,
   output logic                                   rsp_is_classify
);

   logic [ogf_pkg::DIM_BITS-1:0]          grid_width_ff, grid_height_ff;
   logic [ogf_pkg::IDX_BITS-1:0]          clear_cnt_ff;
   logic                                  op_ff;
   logic signed [ogf_pkg::VALUE_BITS-1:0] value_ff;
   logic [ogf_pkg::COORD_BITS-1:0]        col_ff, row_ff;
   logic [ogf_pkg::PROD_BITS-1:0]         prod_ff;
   logic                                  bound_ff;
   logic [ogf_pkg::SUM_BITS-1:0]          sum;
   logic [ogf_pkg::IDX_BITS-1:0]          idx_ff;
   logic                                  oob_ff;
   logic                                  rsp_valid_ff;
   logic [ogf_pkg::CLASS_BITS-1:0]        class_ff;
   logic [ogf_pkg::TOTAL_BITS-1:0]        total_ff;
   logic                                  out_oob_ff;
   logic                                  is_classify_ff;

   logic                                  ram_we;
   logic [ogf_pkg::IDX_BITS-1:0]          ram_waddr;
   logic [ogf_pkg::ENTRY_BITS-1:0]        ram_wdata, ram_rdata;
   logic [ogf_pkg::COUNT_BITS-1:0]        seen, blocked, seen_in, blocked_in;
   logic [31:0]                           seen_wide;
   logic [ogf_pkg::TOTAL_BITS-1:0]        total_in;
   logic [ogf_pkg::CLASS_BITS-1:0]        class_in;
   logic [ogf_pkg::COUNT_BITS+1:0]        blocked_x4, seen_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= ogf_pkg::WIDTH_RESET;
         grid_height_ff <= ogf_pkg::HEIGHT_RESET;
         clear_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               ogf_pkg::CSR_MAP_WIDTH:  grid_width_ff  <= csr_data;
               ogf_pkg::CSR_MAP_HEIGHT: grid_height_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
         if (cmd.write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.clear_last = (clear_cnt_ff == ogf_pkg::IDX_BITS'(ogf_pkg::MAP_CELLS - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign sum = ogf_pkg::SUM_BITS'(prod_ff) + ogf_pkg::SUM_BITS'(col_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         value_ff <= req_cell_value;
         col_ff   <= ogf_pkg::COORD_BITS'(req_offset_x) + ogf_pkg::COORD_BITS'(req_local_col);
         row_ff   <= ogf_pkg::COORD_BITS'(req_offset_y) + ogf_pkg::COORD_BITS'(req_local_row);
      end
      if (cmd.calc) begin
         prod_ff  <= ogf_pkg::PROD_BITS'(grid_width_ff) * ogf_pkg::PROD_BITS'(row_ff);
         bound_ff <= (col_ff >= ogf_pkg::COORD_BITS'(grid_width_ff))
                  || (row_ff >= ogf_pkg::COORD_BITS'(grid_height_ff));
      end
      if (cmd.index) begin
         idx_ff <= sum[ogf_pkg::IDX_BITS-1:0];
         oob_ff <= bound_ff || (sum >= ogf_pkg::SUM_BITS'(ogf_pkg::MAP_CELLS));
      end
      if (cmd.write) begin
         class_ff       <= class_in;
         total_ff       <= total_in;
         out_oob_ff     <= oob_ff;
         is_classify_ff <= op_ff;
      end
   end

   assign seen    = ram_rdata[ogf_pkg::COUNT_BITS-1:0];
   assign blocked = ram_rdata[ogf_pkg::ENTRY_BITS-1:ogf_pkg::COUNT_BITS];

   assign seen_wide  = 32'(seen);
   assign blocked_x4 = {blocked, 2'b00};
   assign seen_ext   = {2'b00, seen};

   always_comb begin
      seen_in    = seen;
      blocked_in = blocked;
      class_in   = ogf_pkg::CLASS_UNKNOWN;
      total_in   = (seen_wide > 32'(ogf_pkg::TOTAL_MAX)) ? ogf_pkg::TOTAL_MAX
                                                          : seen_wide[ogf_pkg::TOTAL_BITS-1:0];
      if (op_ff == ogf_pkg::OP_CLASSIFY) begin
         seen_in    = '0;
         blocked_in = '0;
         if (seen == '0) begin
            class_in = ogf_pkg::CLASS_UNKNOWN;
         end else if (blocked_x4 >= seen_ext) begin
            class_in = ogf_pkg::CLASS_OCCUPIED;
         end else begin
            class_in = ogf_pkg::CLASS_FREE;
         end
      end else if (value_ff == ogf_pkg::VALUE_BLOCKED) begin
         seen_in    = (seen == ogf_pkg::COUNT_MAX) ? seen : seen + 1'b1;
         blocked_in = (blocked == ogf_pkg::COUNT_MAX) ? blocked : blocked + 1'b1;
      end else if (value_ff == ogf_pkg::VALUE_FREE) begin
         seen_in = (seen == ogf_pkg::COUNT_MAX) ? seen : seen + 1'b1;
      end
      if (oob_ff) begin
         class_in = ogf_pkg::CLASS_UNKNOWN;
         total_in = '0;
      end
   end

   assign ram_we    = cmd.clear || (cmd.write && !oob_ff);
   assign ram_waddr = cmd.clear ? clear_cnt_ff : idx_ff;
   assign ram_wdata = cmd.clear ? '0 : {blocked_in, seen_in};

   ogf_ram #(
      .WIDTH (ogf_pkg::ENTRY_BITS),
      .DEPTH (ogf_pkg::MAP_CELLS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.read),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_class  = class_ff;
   assign rsp_seen_total  = total_ff;
   assign rsp_out_of_map  = out_oob_ff;
   assign rsp_is_classify = is_classify_ff;

   a_write_in_map: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (cmd.clear || !oob_ff))
      else $error("counter store written for an address outside the map");

   a_oob_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_out_of_map)
         |-> (total_ff == '0) && (class_ff == ogf_pkg::CLASS_UNKNOWN))
      else $error("out-of-map result carries cell data");

endmodule

// ----- rtl/core/occupancy_grid_fusion.sv -----
// Top level of the occupancy grid fusion block.
// Joins ogf_ctrl and ogf_dp; uses ogf_pkg and, through ogf_dp, ogf_ram.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_tvalid/tready    tdata: cell fields, tuser: operation
//   rsp_     out        rsp_tvalid/tready    tdata: result fields, tuser: is_classify
//   csr_     in         csr_valid/ready      csr_index, csr_data
//
// Each item passes from acceptance to its result through the address add,
// the width multiply, the index add and the registered read and write of
// the counter store. After reset a clearing pass writes zero to every cell,
// one per cycle, before the first item is taken; configuration writes are
// taken at any time outside reset.
// A stalled result holds the next item in its last step until the result is taken.
`timescale 1ns / 1ps

module occupancy_grid_fusion (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] offset_x, [31:16] offset_y, [41:32] local_col, [51:42] local_row,
   // [59:52] cell_value, [63:60] zero.
   input  logic [63:0] req_tdata,
   // [0] operation.
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] cell_class, [17:2] seen_total, [18] out_of_map, [23:19] zero.
   output logic [23:0] rsp_tdata,
   // [0] is_classify.
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   ogf_pkg::cmd_type                      cmd;
   ogf_pkg::sts_type                      sts;
   logic [ogf_pkg::CLASS_BITS-1:0]        cell_class;
   logic [ogf_pkg::TOTAL_BITS-1:0]        seen_total;
   logic                                  out_of_map;

   assign csr_ready = !reset;

   ogf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ogf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_operation   (req_tuser),
      .req_offset_x    (req_tdata[15:0]),
      .req_offset_y    (req_tdata[31:16]),
      .req_local_col   (req_tdata[41:32]),
      .req_local_row   (req_tdata[51:42]),
      .req_cell_value  (req_tdata[59:52]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_cell_class  (cell_class),
      .rsp_seen_total  (seen_total),
      .rsp_out_of_map  (out_of_map),
      .rsp_is_classify (rsp_tuser)
   );

   assign rsp_tdata = {5'b00000, out_of_map, seen_total, cell_class};

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

endmodule

// ----- tb/sv/tb_occupancy_grid_fusion.sv -----
// Self-checking testbench for occupancy_grid_fusion: drives cell items on the req_ stream,
// predicts every result with its own copy of the counter store and the map size registers,
// and checks each rsp_ item in order. Depends on ogf_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_occupancy_grid_fusion;
   import ogf_pkg::*;

   localparam int WATCHDOG_LIMIT = 300000;
   localparam int SETTLE_CYCLES  = 12;

   typedef struct {
      logic                  op;
      bit [OFFS_BITS-1:0]    offset_x;
      bit [OFFS_BITS-1:0]    offset_y;
      bit [LOCAL_BITS-1:0]   local_col;
      bit [LOCAL_BITS-1:0]   local_row;
      bit [VALUE_BITS-1:0]   cell_value;
   } cell_item_type;

   typedef struct {
      logic [CLASS_BITS-1:0] cell_class;
      logic [TOTAL_BITS-1:0] seen_total;
      logic                  out_of_map;
      logic                  is_classify;
   } cell_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;

   bit [COUNT_BITS-1:0] seen_store [MAP_CELLS];
   bit [COUNT_BITS-1:0] blocked_store [MAP_CELLS];
   bit [DIM_BITS-1:0]   grid_width = WIDTH_RESET;
   bit [DIM_BITS-1:0]   grid_height = HEIGHT_RESET;
   bit [COORD_BITS-1:0] hot_col [6];
   bit [COORD_BITS-1:0] hot_row [6];

   cell_result_type pending_cells [$];
   int              mismatches = 0;
   int              quiet_cycles = 0;
   bit              bursty = 1'b1;

   occupancy_grid_fusion dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic cell_result_type fuse_cell(cell_item_type it);
      bit [COORD_BITS-1:0] gcol;
      bit [COORD_BITS-1:0] grow;
      longint unsigned     gidx;
      bit [COUNT_BITS-1:0] seen;
      bit [COUNT_BITS-1:0] blocked;
      cell_result_type     r;
      r.cell_class  = CLASS_UNKNOWN;
      r.seen_total  = '0;
      r.out_of_map  = 1'b0;
      r.is_classify = it.op;
      gcol = {1'b0, it.offset_x} + COORD_BITS'(it.local_col);
      grow = {1'b0, it.offset_y} + COORD_BITS'(it.local_row);
      if (gcol >= COORD_BITS'(grid_width) || grow >= COORD_BITS'(grid_height)) begin
         r.out_of_map = 1'b1;
         return r;
      end
      gidx = longint'(grid_width) * longint'(grow) + longint'(gcol);
      if (gidx >= MAP_CELLS) begin
         r.out_of_map = 1'b1;
         return r;
      end
      seen = seen_store[gidx];
      blocked = blocked_store[gidx];
      r.seen_total = seen;
      if (it.op == OP_ACCUMULATE) begin
         if (it.cell_value == VALUE_BLOCKED) begin
            if (blocked != COUNT_MAX) blocked_store[gidx] = blocked + 1'b1;
            if (seen != COUNT_MAX) seen_store[gidx] = seen + 1'b1;
         end else if (it.cell_value == VALUE_FREE) begin
            if (seen != COUNT_MAX) seen_store[gidx] = seen + 1'b1;
         end
      end else begin
         if (seen == 0)
            r.cell_class = CLASS_UNKNOWN;
         else if (4 * longint'(blocked) >= longint'(seen))
            r.cell_class = CLASS_OCCUPIED;
         else
            r.cell_class = CLASS_FREE;
         seen_store[gidx] = '0;
         blocked_store[gidx] = '0;
      end
      return r;
   endfunction

   function automatic cell_item_type make_cell(logic op, int ox, int oy, int lc, int lr,
                                               logic signed [VALUE_BITS-1:0] value);
      cell_item_type it;
      it.op = op;
      it.offset_x = OFFS_BITS'(ox);
      it.offset_y = OFFS_BITS'(oy);
      it.local_col = LOCAL_BITS'(lc);
      it.local_row = LOCAL_BITS'(lr);
      it.cell_value = value;
      return it;
   endfunction

   function automatic bit map_has_cells();
      return grid_width != 0 && grid_height != 0;
   endfunction

   function automatic void pick_cell(output bit [COORD_BITS-1:0] gcol,
                                     output bit [COORD_BITS-1:0] grow);
      int max_row;
      int max_col;
      max_row = MAP_CELLS / int'(grid_width);
      if (max_row > int'(grid_height) - 1) max_row = int'(grid_height) - 1;
      if (max_row > MAP_CELLS - 1) max_row = MAP_CELLS - 1;
      grow = COORD_BITS'($urandom_range(0, max_row));
      max_col = MAP_CELLS - 1 - int'(grow) * int'(grid_width);
      if (max_col > int'(grid_width) - 1) max_col = int'(grid_width) - 1;
      gcol = COORD_BITS'($urandom_range(0, max_col));
   endfunction

   function automatic void split_coord(input bit [COORD_BITS-1:0] g, input bit zero_part,
                                       output bit [OFFS_BITS-1:0] base,
                                       output bit [LOCAL_BITS-1:0] part);
      int top;
      top = (g > 1023) ? 1023 : int'(g);
      part = zero_part ? '0 : LOCAL_BITS'($urandom_range(0, top));
      base = OFFS_BITS'(g - COORD_BITS'(part));
   endfunction

   function automatic cell_item_type random_cell();
      cell_item_type       it;
      bit [COORD_BITS-1:0] gcol;
      bit [COORD_BITS-1:0] grow;
      int                  roll;
      int                  slot;
      bit                  zero_part;
      roll = $urandom_range(0, 99);
      if (roll < 10 || !map_has_cells()) begin
         it.op = 1'($urandom_range(0, 1));
         it.offset_x = OFFS_BITS'($urandom);
         it.offset_y = OFFS_BITS'($urandom);
         it.local_col = LOCAL_BITS'($urandom);
         it.local_row = LOCAL_BITS'($urandom);
         it.cell_value = VALUE_BITS'($urandom);
         return it;
      end
      if (roll < 55) begin
         slot = $urandom_range(0, 5);
         gcol = hot_col[slot];
         grow = hot_row[slot];
      end else begin
         pick_cell(gcol, grow);
      end
      if (roll >= 95) begin
         if ($urandom_range(0, 1)) gcol = COORD_BITS'(grid_width);
         else grow = COORD_BITS'(grid_height);
      end
      it.op = ($urandom_range(0, 4) == 0) ? OP_CLASSIFY : OP_ACCUMULATE;
      zero_part = (it.op == OP_CLASSIFY) && ($urandom_range(0, 9) < 7);
      split_coord(gcol, zero_part, it.offset_x, it.local_col);
      split_coord(grow, zero_part, it.offset_y, it.local_row);
      roll = $urandom_range(0, 99);
      if (roll < 45) it.cell_value = VALUE_BLOCKED;
      else if (roll < 80) it.cell_value = VALUE_FREE;
      else if (roll < 90) it.cell_value = 8'hFF;
      else it.cell_value = VALUE_BITS'($urandom);
      return it;
   endfunction

   task automatic send_cell(cell_item_type it);
      cell_result_type want;
      if (bursty && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = it.op;
      req_tdata = {4'b0, it.cell_value, it.local_row, it.local_col, it.offset_y, it.offset_x};
      do @(posedge clock); while (!req_tready);
      want = fuse_cell(it);
      pending_cells.insert(pending_cells.size(), want);
   endtask

   task automatic settle_map();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_map_register(logic index, bit [DIM_BITS-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_MAP_WIDTH) grid_width = value;
      else grid_height = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_map(int width, int height);
      settle_map();
      write_map_register(CSR_MAP_WIDTH, DIM_BITS'(width));
      write_map_register(CSR_MAP_HEIGHT, DIM_BITS'(height));
      if (map_has_cells()) begin
         for (int i = 0; i < 6; i++) pick_cell(hot_col[i], hot_row[i]);
      end
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_cell(random_cell());
   endtask

   // Runs on the reset map of 256 by 256 cells.
   task automatic test_directed_cases();
      send_cell(make_cell(OP_ACCUMULATE, 0, 0, 0, 0, VALUE_BLOCKED));
      send_cell(make_cell(OP_ACCUMULATE, 0, 0, 0, 0, VALUE_FREE));
      send_cell(make_cell(OP_ACCUMULATE, 0, 0, 0, 0, -8'sd1));
      send_cell(make_cell(OP_ACCUMULATE, 0, 0, 0, 0, 8'sd127));
      send_cell(make_cell(OP_ACCUMULATE, 0, 0, 0, 0, -8'sd128));
      send_cell(make_cell(OP_ACCUMULATE, 0, 0, 0, 0, 8'sd101));
      send_cell(make_cell(OP_CLASSIFY, 0, 0, 0, 0, VALUE_FREE));
      send_cell(make_cell(OP_CLASSIFY, 0, 0, 0, 0, VALUE_FREE));
      // A quarter of the hits blocked is still occupied; one more free hit makes it free.
      send_cell(make_cell(OP_ACCUMULATE, 3, 5, 2, 0, VALUE_BLOCKED));
      for (int i = 0; i < 3; i++) send_cell(make_cell(OP_ACCUMULATE, 0, 5, 5, 0, VALUE_FREE));
      send_cell(make_cell(OP_CLASSIFY, 5, 5, 0, 0, VALUE_FREE));
      send_cell(make_cell(OP_ACCUMULATE, 6, 5, 0, 0, VALUE_BLOCKED));
      for (int i = 0; i < 4; i++) send_cell(make_cell(OP_ACCUMULATE, 6, 0, 0, 5, VALUE_FREE));
      send_cell(make_cell(OP_CLASSIFY, 1, 5, 5, 0, VALUE_BLOCKED));
      send_cell(make_cell(OP_ACCUMULATE, 200, 0, 55, 255, VALUE_BLOCKED));
      send_cell(make_cell(OP_CLASSIFY, 250, 250, 5, 5, VALUE_FREE));
      send_cell(make_cell(OP_ACCUMULATE, 200, 0, 56, 0, VALUE_BLOCKED));
      send_cell(make_cell(OP_ACCUMULATE, 0, 0, 1023, 1023, VALUE_FREE));
      send_cell(make_cell(OP_CLASSIFY, 65535, 65535, 1023, 1023, VALUE_FREE));
   endtask

   task automatic test_register_extremes();
      set_map(0, 256);
      run_random(30);
      set_map(256, 0);
      run_random(30);
      set_map(65535, 65535);
      run_random(40);
      set_map(1, 65535);
      send_cell(make_cell(OP_ACCUMULATE, 0, 65535, 0, 0, VALUE_BLOCKED));
      send_cell(make_cell(OP_CLASSIFY, 0, 65534, 0, 1, VALUE_FREE));
      send_cell(make_cell(OP_ACCUMULATE, 0, 65535, 0, 1, VALUE_BLOCKED));
      run_random(40);
      set_map(300, 300);
      send_cell(make_cell(OP_ACCUMULATE, 299, 219, 0, 0, VALUE_BLOCKED));
      send_cell(make_cell(OP_ACCUMULATE, 35, 218, 0, 0, VALUE_BLOCKED));
      run_random(40);
   endtask

   task automatic test_repeated_hits();
      set_map(256, 256);
      bursty = 1'b0;
      for (int i = 0; i < 40; i++)
         send_cell(make_cell(OP_ACCUMULATE, 17, 3, 0, 0, VALUE_BLOCKED));
      send_cell(make_cell(OP_ACCUMULATE, 17, 3, 0, 0, VALUE_FREE));
      send_cell(make_cell(OP_CLASSIFY, 17, 3, 0, 0, VALUE_FREE));
      send_cell(make_cell(OP_CLASSIFY, 17, 3, 0, 0, VALUE_FREE));
      bursty = 1'b1;
   endtask

   task automatic test_random_fusion();
      set_map(16, 16);
      run_random(250);
      set_map(256, 256);
      run_random(250);
      set_map(300, 220);
      run_random(200);
      set_map(64, 64);
      run_random(100);
      bursty = 1'b0;
      run_random(250);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (bursty && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      cell_result_type want;
      cell_result_type got;
      if (rsp_tvalid && rsp_tready) begin
         got.cell_class  = rsp_tdata[1:0];
         got.seen_total  = rsp_tdata[17:2];
         got.out_of_map  = rsp_tdata[18];
         got.is_classify = rsp_tuser;
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: class %0d seen %0d out %0d classify %0d",
                        got.cell_class, got.seen_total, got.out_of_map, got.is_classify);
         end else begin
            want = pending_cells.pop_front();
            if (got.cell_class !== want.cell_class || got.seen_total !== want.seen_total ||
                got.out_of_map !== want.out_of_map || got.is_classify !== want.is_classify) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch at %0t: class %0d/%0d seen %0d/%0d ",
                            "out %0d/%0d classify %0d/%0d (expected/actual)"},
                           $realtime, want.cell_class, got.cell_class,
                           want.seen_total, got.seen_total, want.out_of_map, got.out_of_map,
                           want.is_classify, got.is_classify);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("occupancy_grid_fusion regression: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_repeated_hits();
      test_random_fusion();
      settle_map();
      if (mismatches == 0 && pending_cells.size() == 0)
         $display("occupancy_grid_fusion regression: pass");
      else
         $display("occupancy_grid_fusion regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/ogf_pkg.sv
rtl/core/ogf_ram.sv
rtl/core/ogf_ctrl.sv
rtl/core/ogf_dp.sv
rtl/core/occupancy_grid_fusion.sv
tb/sv/tb_occupancy_grid_fusion.sv
